[rtl/igv_pkg.sv]
// Shared types and constants of the inverse Gaussian variate transform.
package igv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS    = 32;
  localparam int DIV_STEPS     = 32;

  localparam logic [30:0] Q_CAP      = 31'h7FFF_FFFF;
  localparam logic [31:0] VAR_MAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] DISP_RESET = 32'h0001_0000;

  // configuration register indexes
  localparam logic [0:0] CFG_FIXED_DISP = 1'b0;
  localparam logic [0:0] CFG_USE_ITEM   = 1'b1;

  // data that rides along the cell chains
  typedef struct packed {
    logic [31:0] m;
    logic [15:0] u;
    logic [30:0] q;
    logic        sat;
    logic        zq;
    logic [31:0] x;
    logic        accept;
    logic        ovf;
  } side_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] lo;
    logic [32:0] den;
    logic [31:0] quo;
  } div_t;

endpackage

[rtl/igv_in_if.sv]
// Request channel carrying one sampler input item.
interface igv_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        mean_value;
  logic signed [15:0] normal_sample;
  logic [15:0]        uniform_sample;
  logic [31:0]        item_dispersion;

  modport source (output valid, mean_value, normal_sample, uniform_sample,
                  item_dispersion, input ready);
  modport sink   (input valid, mean_value, normal_sample, uniform_sample,
                  item_dispersion, output ready);
endinterface

[rtl/igv_out_if.sv]
// Result channel carrying one inverse Gaussian variate.
interface igv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] variate;
  logic        saturated;

  modport source (output valid, variate, saturated, input ready);
  modport sink   (input valid, variate, saturated, output ready);
endinterface

[rtl/inverse_gaussian_variate_transform_unit.sv]
// Order: S1-S4, square root chain, S5, divider 1, B1, B2, divider 2, out reg.
// Throughput: one request per cycle; a 32-cell square root chain and two
// 32-cell divider chains each resolve one bit per cell per cycle.
// The whole pipeline holds while a finished result waits on out_chan.ready.
// Reset (synchronous, rst_n low): pipeline emptied, dispersion 1.0, fixed mode.
// Top level of the inverse Gaussian variate transform.
module inverse_gaussian_variate_transform_unit #(
  parameter int FRAC_BITS = igv_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  igv_in_if.sink      in_chan,
  igv_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int QSH = FRAC_BITS - 8;
  localparam int RSH = FRAC_BITS + 2;
  localparam int SQ  = igv_pkg::SQRT_STEPS;
  localparam int DV  = igv_pkg::DIV_STEPS;

  logic [31:0] fixed_disp_r;
  logic        use_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_disp_r <= igv_pkg::DISP_RESET;
      use_item_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        igv_pkg::CFG_FIXED_DISP: fixed_disp_r <= cfg_data;
        igv_pkg::CFG_USE_ITEM:   use_item_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // S1: phi*mu and z^2
  logic [31:0] p_sel;
  logic [15:0] z_raw, mag;
  logic [31:0] zz_full;
  logic [63:0] pm_nxt;
  logic        s1_v_r;
  logic [63:0] pm_r;
  logic [30:0] zz_r;
  logic [31:0] s1_m_r;
  logic [15:0] s1_u_r;

  always_comb begin
    p_sel   = use_item_r ? in_chan.item_dispersion : fixed_disp_r;
    z_raw   = in_chan.normal_sample;
    mag     = z_raw[15] ? (~z_raw + 16'd1) : z_raw;
    zz_full = mag * mag;
    pm_nxt  = p_sel * in_chan.mean_value;
  end

  // S2: split product against z^2
  logic        s2_v_r;
  logic [62:0] lo_r, hi_r;
  logic [31:0] s2_m_r;
  logic [15:0] s2_u_r;

  // S3: q with clamp
  logic [63:0] qsum, qfull;
  logic [30:0] q_nxt;
  logic        qsat_nxt;
  logic        s3_v_r;
  logic [30:0] s3_q_r;
  logic        s3_sat_r;
  logic [31:0] s3_m_r;
  logic [15:0] s3_u_r;

  always_comb begin
    qsum  = {1'b0, hi_r} + {33'b0, lo_r[62:32]};
    qfull = qsum >> QSH;
    if (qfull > {33'b0, igv_pkg::Q_CAP}) begin
      q_nxt    = igv_pkg::Q_CAP;
      qsat_nxt = 1'b1;
    end else begin
      q_nxt    = qfull[30:0];
      qsat_nxt = 1'b0;
    end
  end

  // S4: radicand q^2 + q*2^(F+2)
  logic [61:0]    qq;
  logic [63:0]    rad_nxt;
  logic           s4_v_r;
  logic [63:0]    rad_r;
  igv_pkg::side_t s4_side_r;

  always_comb begin
    qq      = s3_q_r * s3_q_r;
    rad_nxt = {2'b0, qq} + ({33'b0, s3_q_r} << RSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_chan.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r     <= pm_nxt;
      zz_r     <= zz_full[30:0];
      s1_m_r   <= in_chan.mean_value;
      s1_u_r   <= in_chan.uniform_sample;
      lo_r     <= pm_r[31:0] * zz_r;
      hi_r     <= pm_r[63:32] * zz_r;
      s2_m_r   <= s1_m_r;
      s2_u_r   <= s1_u_r;
      s3_q_r   <= q_nxt;
      s3_sat_r <= qsat_nxt;
      s3_m_r   <= s2_m_r;
      s3_u_r   <= s2_u_r;
      rad_r    <= rad_nxt;
      s4_side_r.m      <= s3_m_r;
      s4_side_r.u      <= s3_u_r;
      s4_side_r.q      <= s3_q_r;
      s4_side_r.sat    <= s3_sat_r;
      s4_side_r.zq     <= (s3_q_r == 31'd0);
      s4_side_r.x      <= '0;
      s4_side_r.accept <= 1'b0;
      s4_side_r.ovf    <= 1'b0;
    end
  end

  // square root chain
  logic           sq_v [0:SQ];
  igv_pkg::sqrt_t sq_d [0:SQ];
  igv_pkg::side_t sq_s [0:SQ];

  assign sq_v[0] = s4_v_r;
  assign sq_d[0] = {rad_r, 64'd0};
  assign sq_s[0] = s4_side_r;

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    igv_sqrt_cell #(.STEP(k)) u_cell (
      .clk, .rst_n, .en,
      .vld_in(sq_v[k]), .d_in(sq_d[k]), .side_in(sq_s[k]),
      .vld_out(sq_v[k+1]), .d_out(sq_d[k+1]), .side_out(sq_s[k+1])
    );
  end

  // S5: x = mu*(s-q)/(s+q) set up
  logic [31:0]    root, diff;
  logic [63:0]    num_nxt;
  logic           s5_v_r;
  logic [63:0]    num_r;
  logic [32:0]    den_r;
  igv_pkg::side_t s5_side_r;

  always_comb begin
    root    = sq_d[SQ].res[31:0];
    diff    = root - {1'b0, sq_s[SQ].q};
    num_nxt = sq_s[SQ].m * diff;
  end

  // first divider chain
  logic           d1_v [0:DV];
  igv_pkg::div_t  d1_d [0:DV];
  igv_pkg::side_t d1_s [0:DV];

  // fields: rem, lo, den, quo
  assign d1_v[0] = s5_v_r;
  assign d1_d[0] = {{2'b0, num_r[63:32]}, num_r[31:0], den_r, 32'd0};
  assign d1_s[0] = s5_side_r;

  for (genvar k = 0; k < DV; k++) begin : g_d1
    igv_div_cell u_cell (
      .clk, .rst_n, .en,
      .vld_in(d1_v[k]), .d_in(d1_d[k]), .side_in(d1_s[k]),
      .vld_out(d1_v[k+1]), .d_out(d1_d[k+1]), .side_out(d1_s[k+1])
    );
  end

  // B1: select root, mu^2
  igv_pkg::side_t b1_side_nxt;
  logic           b1_v_r;
  igv_pkg::side_t b1_side_r;
  logic [63:0]    mm_r;

  always_comb begin
    b1_side_nxt   = d1_s[DV];
    b1_side_nxt.x = d1_s[DV].zq ? d1_s[DV].m : d1_d[DV].quo;
    b1_side_nxt.sat = d1_s[DV].sat || (b1_side_nxt.x == 32'd0);
  end

  // B2: accept test and reciprocal set up
  logic [48:0]    acc_lhs;
  igv_pkg::side_t b2_side_nxt;
  logic           b2_v_r;
  igv_pkg::side_t b2_side_r;
  logic [63:0]    mm2_r;

  always_comb begin
    acc_lhs = b1_side_r.u * ({1'b0, b1_side_r.m} + {1'b0, b1_side_r.x});
    b2_side_nxt        = b1_side_r;
    b2_side_nxt.accept = (acc_lhs <= {1'b0, b1_side_r.m, 16'b0});
    b2_side_nxt.ovf    = (mm_r[63:32] >= b1_side_r.x);
  end

  // second divider chain: mu^2 / x
  logic           d2_v [0:DV];
  igv_pkg::div_t  d2_d [0:DV];
  igv_pkg::side_t d2_s [0:DV];

  assign d2_v[0] = b2_v_r;
  assign d2_d[0] = {{2'b0, mm2_r[63:32]}, mm2_r[31:0], {1'b0, b2_side_r.x}, 32'd0};
  assign d2_s[0] = b2_side_r;

  for (genvar k = 0; k < DV; k++) begin : g_d2
    igv_div_cell u_cell (
      .clk, .rst_n, .en,
      .vld_in(d2_v[k]), .d_in(d2_d[k]), .side_in(d2_s[k]),
      .vld_out(d2_v[k+1]), .d_out(d2_d[k+1]), .side_out(d2_s[k+1])
    );
  end

  // output register
  logic [31:0] var_nxt;
  logic        sat_nxt;
  logic [31:0] variate_r;
  logic        saturated_r;

  always_comb begin
    if (d2_s[DV].accept) begin
      var_nxt = d2_s[DV].x;
      sat_nxt = d2_s[DV].sat;
    end else if (d2_s[DV].ovf) begin
      var_nxt = igv_pkg::VAR_MAX;
      sat_nxt = 1'b1;
    end else begin
      var_nxt = d2_d[DV].quo;
      sat_nxt = d2_s[DV].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r      <= 1'b0;
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s5_v_r      <= sq_v[SQ];
      b1_v_r      <= d1_v[DV];
      b2_v_r      <= b1_v_r;
      out_valid_r <= d2_v[DV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r       <= num_nxt;
      den_r       <= {1'b0, root} + {2'b0, sq_s[SQ].q};
      s5_side_r   <= sq_s[SQ];
      b1_side_r   <= b1_side_nxt;
      mm_r        <= d1_s[DV].m * d1_s[DV].m;
      b2_side_r   <= b2_side_nxt;
      mm2_r       <= mm_r;
      variate_r   <= var_nxt;
      saturated_r <= sat_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.variate   = variate_r;
  assign out_chan.saturated = saturated_r;

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> s1_v_r)
    else $error("accepted request missing from first stage");

  // the smaller root never exceeds the mean
  a_root_le_mean: assert property (@(posedge clk) disable iff (!rst_n)
    b1_v_r |-> (b1_side_r.x <= b1_side_r.m))
    else $error("root above mean");

  // a zero variate is always flagged
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (variate_r == 32'd0)) |-> saturated_r)
    else $error("zero variate without saturation flag");

  // a stall freezes the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(b2_v_r) && $stable(s5_v_r) && $stable(out_valid_r)))
    else $error("pipeline moved during stall");

endmodule

[rtl/igv_sqrt_cell.sv]
// One cell of the integer square root chain: resolves one root bit.
module igv_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  igv_pkg::sqrt_t d_in,
  input  igv_pkg::side_t side_in,
  output logic           vld_out,
  output igv_pkg::sqrt_t d_out,
  output igv_pkg::side_t side_out
);

  localparam logic [63:0] BIT = 64'd1 << (2 * (igv_pkg::SQRT_STEPS - 1 - STEP));

  logic [63:0]    trial;
  igv_pkg::sqrt_t d_nxt;

  always_comb begin
    trial = d_in.res + BIT;
    if (d_in.v >= trial) begin
      d_nxt.v   = d_in.v - trial;
      d_nxt.res = (d_in.res >> 1) + BIT;
    end else begin
      d_nxt.v   = d_in.v;
      d_nxt.res = d_in.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out    <= d_nxt;
      side_out <= side_in;
    end
  end

endmodule

[rtl/igv_div_cell.sv]
// One cell of the restoring divider chain: resolves one quotient bit.
module igv_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  igv_pkg::div_t  d_in,
  input  igv_pkg::side_t side_in,
  output logic           vld_out,
  output igv_pkg::div_t  d_out,
  output igv_pkg::side_t side_out
);

  logic [33:0]   sh;
  logic          qbit;
  igv_pkg::div_t d_nxt;

  always_comb begin
    sh   = {d_in.rem[32:0], d_in.lo[31]};
    qbit = (sh >= {1'b0, d_in.den});
    d_nxt.rem = qbit ? (sh - {1'b0, d_in.den}) : sh;
    d_nxt.lo  = {d_in.lo[30:0], 1'b0};
    d_nxt.den = d_in.den;
    d_nxt.quo = {d_in.quo[30:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out    <= d_nxt;
      side_out <= side_in;
    end
  end

endmodule
